[rtl/core/pshd_pkg.sv]
`default_nettype none

package pshd_pkg;

  // Palette size and the address width that follows from it.
  localparam int PALETTE_ENTRIES = 4096;
  localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
  localparam logic [15:0] IDX_MASK = 16'(PALETTE_ENTRIES - 1);

  // Channel widths.
  localparam int RGB_W   = 24;
  localparam int CODE_W  = 16;
  localparam int ATTR_W  = 16;
  localparam int PIDX_W  = 12;
  localparam int GAIN_W  = 16;
  localparam int PROD_W  = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 72;

  // Q2.14 gain constants.
  localparam logic [GAIN_W-1:0] GAIN_ONE   = 16'h4000;
  localparam int                GAIN_SHIFT = 14;

  // Queue between the lookup front and the scaling back.
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_WRITE = 1'b1
  } pshd_cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SH_ATTR_SEL     = 3'd0,
    CFG_HI_ATTR_SEL     = 3'd1,
    CFG_SHADOW_GAIN     = 3'd2,
    CFG_HIGHLIGHT_GAIN  = 3'd3,
    CFG_FORCE_SHADOW    = 3'd4,
    CFG_FORCE_HIGHLIGHT = 3'd5,
    CFG_SKIP_TWO_BITS   = 3'd6
  } pshd_cfg_idx_t;

  // Which gain the back end applies; bit 1 is shadow, bit 0 is highlight.
  typedef enum logic [1:0] {
    GS_NONE      = 2'b00,
    GS_HIGHLIGHT = 2'b01,
    GS_SHADOW    = 2'b10,
    GS_BOTH      = 2'b11
  } pshd_gain_sel_t;

  typedef struct packed {
    logic [ATTR_W-1:0] sh_attr_sel;
    logic [ATTR_W-1:0] hi_attr_sel;
    logic [GAIN_W-1:0] shadow_gain;
    logic [GAIN_W-1:0] highlight_gain;
    logic [PROD_W-1:0] both_gain;
    logic              force_shadow;
    logic              force_highlight;
    logic              skip_two_bits;
  } pshd_cfg_t;

  typedef struct packed {
    logic [RGB_W-1:0] pen;
    pshd_gain_sel_t   sel;
  } pshd_item_t;

endpackage

`default_nettype wire

[rtl/core/palette_shadow_highlight_dac_top.sv]
// Palette lookup and shadow/highlight DAC stage.
// Input stream: in_tuser selects the transaction kind. A pixel transaction
// (in_tuser 0) carries a colour code and an attribute word; a palette write
// (in_tuser 1) carries an entry number and a 24-bit RGB pen. Only pixel
// transactions produce an output transaction, one 24-bit RGB word each.
// Configuration: cfg_we writes cfg_wdata into register cfg_index
// (0 shadow mask, 1 highlight mask, 2 shadow gain, 3 highlight gain,
// 4 force shadow, 5 force highlight, 6 skip two bits). Write it while idle.
// Throughput: one transaction per cycle while in_tready is high, set by the
// single palette RAM port that serves exactly one write or one lookup per transaction.
// Path: an accepted pixel passes the RAM read, the queue write, then the
// scaler's output register before it is presented on out_tvalid.
// Stall: the output register holds its word while out_tready is low; a
// four-entry queue keeps taking pixels until the queue and the lookup stage
// together hold four, then in_tready drops.
// Reset: configuration returns to unity gains and clear masks, the queue and
// output register are emptied. Palette contents are undefined until written;
// there is no clearing pass, so every entry must be written before use.
`default_nettype none

module palette_shadow_highlight_dac_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: color_code[15:0], attribute[31:16], pen_index[43:32],
  // pen_rgb[67:44], zero fill[71:68]
  input  logic [pshd_pkg::IN_DATA_W-1:0]    in_tdata,
  // tuser: command[0]
  input  logic [0:0]                        in_tuser,
  // Output stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata: pixel_rgb[23:0]
  output logic [pshd_pkg::RGB_W-1:0]        out_tdata,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [pshd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pshd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  pshd_pkg::pshd_cfg_t              cfg;
  logic [pshd_pkg::QCNT_W-1:0]      q_count;
  logic                             ram_we;
  logic                             ram_re;
  logic [pshd_pkg::PAL_AW-1:0]      ram_addr;
  logic [pshd_pkg::RGB_W-1:0]       ram_wdata;
  logic [pshd_pkg::RGB_W-1:0]       ram_rdata;
  logic                             push_valid;
  pshd_pkg::pshd_item_t             push_item;
  logic                             pop;
  logic                             head_valid;
  pshd_pkg::pshd_item_t             head_item;

  // Configuration registers and combined gain.
  pshd_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Accept, map and classify; drives the palette port.
  pshd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .cmd        (pshd_pkg::pshd_cmd_t'(in_tuser[0])),
    .color_code (in_tdata[15:0]),
    .attribute  (in_tdata[31:16]),
    .pen_index  (in_tdata[43:32]),
    .pen_rgb    (in_tdata[67:44]),
    .cfg        (cfg),
    .q_count    (q_count),
    .ram_we     (ram_we),
    .ram_re     (ram_re),
    .ram_addr   (ram_addr),
    .ram_wdata  (ram_wdata),
    .ram_rdata  (ram_rdata),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  pshd_ram #(
    .WIDTH (pshd_pkg::RGB_W),
    .DEPTH (pshd_pkg::PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  pshd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_item  (push_item),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item),
    .count      (q_count)
  );

  // Gain scaling and output register.
  pshd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .cfg        (cfg),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_tdata)
  );

endmodule

`default_nettype wire

[rtl/core/pshd_ram.sv]
`default_nettype none

module pshd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single port, registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/core/pshd_regs.sv]
`default_nettype none

module pshd_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [pshd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pshd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output pshd_pkg::pshd_cfg_t              cfg
);

  logic [pshd_pkg::ATTR_W-1:0] sh_attr_sel_r, sh_attr_sel_nxt;
  logic [pshd_pkg::ATTR_W-1:0] hi_attr_sel_r, hi_attr_sel_nxt;
  logic [pshd_pkg::GAIN_W-1:0] shadow_gain_r, shadow_gain_nxt;
  logic [pshd_pkg::GAIN_W-1:0] highlight_gain_r, highlight_gain_nxt;
  logic                        force_shadow_r, force_shadow_nxt;
  logic                        force_highlight_r, force_highlight_nxt;
  logic                        skip_two_bits_r, skip_two_bits_nxt;
  logic [pshd_pkg::PROD_W-1:0] both_gain_r;
  logic [31:0]                 gain_prod;

  // Register write decode.
  always_comb begin
    sh_attr_sel_nxt     = sh_attr_sel_r;
    hi_attr_sel_nxt     = hi_attr_sel_r;
    shadow_gain_nxt     = shadow_gain_r;
    highlight_gain_nxt  = highlight_gain_r;
    force_shadow_nxt    = force_shadow_r;
    force_highlight_nxt = force_highlight_r;
    skip_two_bits_nxt   = skip_two_bits_r;
    if (cfg_we) begin
      case (pshd_pkg::pshd_cfg_idx_t'(cfg_index))
        pshd_pkg::CFG_SH_ATTR_SEL:     sh_attr_sel_nxt     = cfg_wdata;
        pshd_pkg::CFG_HI_ATTR_SEL:     hi_attr_sel_nxt     = cfg_wdata;
        pshd_pkg::CFG_SHADOW_GAIN:     shadow_gain_nxt     = cfg_wdata;
        pshd_pkg::CFG_HIGHLIGHT_GAIN:  highlight_gain_nxt  = cfg_wdata;
        pshd_pkg::CFG_FORCE_SHADOW:    force_shadow_nxt    = cfg_wdata[0];
        pshd_pkg::CFG_FORCE_HIGHLIGHT: force_highlight_nxt = cfg_wdata[0];
        pshd_pkg::CFG_SKIP_TWO_BITS:   skip_two_bits_nxt   = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_attr_sel_r     <= '0;
      hi_attr_sel_r     <= '0;
      shadow_gain_r     <= pshd_pkg::GAIN_ONE;
      highlight_gain_r  <= pshd_pkg::GAIN_ONE;
      force_shadow_r    <= 1'b0;
      force_highlight_r <= 1'b0;
      skip_two_bits_r   <= 1'b0;
    end else begin
      sh_attr_sel_r     <= sh_attr_sel_nxt;
      hi_attr_sel_r     <= hi_attr_sel_nxt;
      shadow_gain_r     <= shadow_gain_nxt;
      highlight_gain_r  <= highlight_gain_nxt;
      force_shadow_r    <= force_shadow_nxt;
      force_highlight_r <= force_highlight_nxt;
      skip_two_bits_r   <= skip_two_bits_nxt;
    end
  end

  // Combined gain depends only on the two gain registers, so it is recomputed
  // continuously and is settled long before a pixel reaches the scaler.
  assign gain_prod = 32'(shadow_gain_r) * 32'(highlight_gain_r) + 32'd8192;

  always_ff @(posedge clk) begin
    both_gain_r <= gain_prod[pshd_pkg::GAIN_SHIFT +: pshd_pkg::PROD_W];
  end

  assign cfg.sh_attr_sel     = sh_attr_sel_r;
  assign cfg.hi_attr_sel     = hi_attr_sel_r;
  assign cfg.shadow_gain     = shadow_gain_r;
  assign cfg.highlight_gain  = highlight_gain_r;
  assign cfg.both_gain       = both_gain_r;
  assign cfg.force_shadow    = force_shadow_r;
  assign cfg.force_highlight = force_highlight_r;
  assign cfg.skip_two_bits   = skip_two_bits_r;

endmodule

`default_nettype wire

[rtl/core/pshd_front.sv]
`default_nettype none

module pshd_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  pshd_pkg::pshd_cmd_t               cmd,
  input  logic [pshd_pkg::CODE_W-1:0]       color_code,
  input  logic [pshd_pkg::ATTR_W-1:0]       attribute,
  input  logic [pshd_pkg::PIDX_W-1:0]       pen_index,
  input  logic [pshd_pkg::RGB_W-1:0]        pen_rgb,
  input  pshd_pkg::pshd_cfg_t               cfg,
  input  logic [pshd_pkg::QCNT_W-1:0]       q_count,
  output logic                              ram_we,
  output logic                              ram_re,
  output logic [pshd_pkg::PAL_AW-1:0]       ram_addr,
  output logic [pshd_pkg::RGB_W-1:0]        ram_wdata,
  input  logic [pshd_pkg::RGB_W-1:0]        ram_rdata,
  output logic                              push_valid,
  output pshd_pkg::pshd_item_t              push_item
);

  logic                     accept;
  logic                     pix_accept;
  logic [pshd_pkg::CODE_W-1:0] code_packed;
  logic [pshd_pkg::CODE_W-1:0] idx;
  logic                     idx_oob;
  logic                     wr_in_range;
  logic                     sh_req;
  logic                     hi_req;
  logic [pshd_pkg::QCNT_W:0] occupancy;

  logic                     s1_v_r, s1_v_nxt;
  pshd_pkg::pshd_gain_sel_t s1_sel_r;
  logic                     s1_oob_r;

  // Room check: entries already queued plus the lookup in flight.
  assign occupancy = {1'b0, q_count} + (pshd_pkg::QCNT_W + 1)'(s1_v_r);
  assign in_ready  = occupancy < (pshd_pkg::QCNT_W + 1)'(pshd_pkg::QDEPTH);
  assign accept     = in_valid && in_ready;
  assign pix_accept = accept && (cmd == pshd_pkg::CMD_PIXEL);

  // Colour code repacking and masking to the palette size.
  assign code_packed = cfg.skip_two_bits
                     ? {2'b00, color_code[15:10], color_code[7:0]}
                     : color_code;
  assign idx     = code_packed & pshd_pkg::IDX_MASK;
  assign idx_oob = !(32'(idx) < 32'(pshd_pkg::PALETTE_ENTRIES));
  assign wr_in_range = 32'(pen_index) < 32'(pshd_pkg::PALETTE_ENTRIES);

  // Shadow and highlight classification.
  assign sh_req = cfg.force_shadow || ((attribute & cfg.sh_attr_sel) != '0);
  assign hi_req = cfg.force_highlight || ((attribute & cfg.hi_attr_sel) != '0);

  // One palette access per transaction: a write or a lookup.
  assign ram_we    = accept && (cmd == pshd_pkg::CMD_WRITE) && wr_in_range;
  assign ram_re    = pix_accept;
  assign ram_addr  = (cmd == pshd_pkg::CMD_WRITE) ? pshd_pkg::PAL_AW'(pen_index)
                                                  : pshd_pkg::PAL_AW'(idx);
  assign ram_wdata = pen_rgb;

  assign s1_v_nxt = pix_accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_accept) begin
      s1_sel_r <= pshd_pkg::pshd_gain_sel_t'({sh_req, hi_req});
      s1_oob_r <= idx_oob;
    end
  end

  // Lookup result goes to the queue the cycle after the read.
  assign push_valid    = s1_v_r;
  assign push_item.pen = s1_oob_r ? '0 : ram_rdata;
  assign push_item.sel = s1_sel_r;

endmodule

`default_nettype wire

[rtl/core/pshd_queue.sv]
`default_nettype none

module pshd_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  pshd_pkg::pshd_item_t          push_item,
  input  logic                          pop,
  output logic                          head_valid,
  output pshd_pkg::pshd_item_t          head_item,
  output logic [pshd_pkg::QCNT_W-1:0]   count
);

  pshd_pkg::pshd_item_t              slots [pshd_pkg::QDEPTH];
  logic [pshd_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [pshd_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [pshd_pkg::QCNT_W-1:0]       count_r, count_nxt;
  logic                              do_pop;

  assign do_pop = pop && (count_r != '0);

  // Pointer and fill count update; the front never pushes into a full queue.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == pshd_pkg::QPTR_W'(pshd_pkg::QDEPTH - 1))
                 ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == pshd_pkg::QPTR_W'(pshd_pkg::QDEPTH - 1))
                 ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_item;
    end
  end

  assign head_valid = count_r != '0;
  assign head_item  = slots[rd_ptr_r];
  assign count      = count_r;

endmodule

`default_nettype wire

[rtl/core/pshd_back.sv]
`default_nettype none

module pshd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          head_valid,
  input  pshd_pkg::pshd_item_t          head_item,
  output logic                          pop,
  input  pshd_pkg::pshd_cfg_t           cfg,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pshd_pkg::RGB_W-1:0]    out_data
);

  logic [pshd_pkg::PROD_W-1:0] gain;
  logic [pshd_pkg::RGB_W-1:0]  scaled;
  logic                        out_valid_r, out_valid_nxt;
  logic [pshd_pkg::RGB_W-1:0]  out_data_r;

  // Scale one 8-bit channel by a Q4.14 gain, round half up, clamp to 255.
  function automatic logic [7:0] scale_chan(input logic [7:0] c,
                                            input logic [pshd_pkg::PROD_W-1:0] g);
    logic [25:0] prod;
    logic [11:0] v;
    prod = 26'(c) * 26'(g) + 26'd8192;
    v    = prod[pshd_pkg::GAIN_SHIFT +: 12];
    return (v[11:8] != '0) ? 8'hff : v[7:0];
  endfunction

  // Gain selection; unity gain leaves every channel unchanged.
  always_comb begin
    case (head_item.sel)
      pshd_pkg::GS_SHADOW:    gain = pshd_pkg::PROD_W'(cfg.shadow_gain);
      pshd_pkg::GS_HIGHLIGHT: gain = pshd_pkg::PROD_W'(cfg.highlight_gain);
      pshd_pkg::GS_BOTH:      gain = cfg.both_gain;
      default:                gain = pshd_pkg::PROD_W'(pshd_pkg::GAIN_ONE);
    endcase
  end

  assign scaled = {scale_chan(head_item.pen[23:16], gain),
                   scale_chan(head_item.pen[15:8], gain),
                   scale_chan(head_item.pen[7:0], gain)};

  // Output register takes a new pixel whenever it is empty or being drained.
  assign pop = head_valid && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= scaled;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[rtl/core/pshd_checker.sv]
`default_nettype none

module pshd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [0:0]                     in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [pshd_pkg::RGB_W-1:0]     out_tdata
);

  logic pix_acc;

  assign pix_acc = in_tvalid && in_tready && (in_tuser[0] == pshd_pkg::CMD_PIXEL);

  // Reset empties the output register.
  a_reset_empties_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output still valid after reset");

  // Reset leaves the block ready for input.
  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready after reset");

  // A stalled output transaction keeps its word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled output changed");

  // Without a pixel in the pipe no output appears; palette writes make none.
  a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid && $past(!out_tvalid) && !$past(pix_acc, 2)) |=> !out_tvalid)
    else $error("output appeared without a pixel transaction");

endmodule

bind palette_shadow_highlight_dac_top pshd_checker u_pshd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
